// ===== hw/rtl/mbet_pkg.sv =====
// Shared types, constants and palette for the escape-time pixel evaluator.
package mbet_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned CHUNK_W     = 32;
  localparam int unsigned COORD_W     = 11;
  localparam int unsigned ITER_W      = 16;
  localparam int unsigned COLOUR_W    = 8;
  localparam int unsigned SHADE_W     = 3;
  localparam int unsigned PALETTE_LEN = 5;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // Register indexes
  localparam logic [0:0] REG_MAX_ITER = 1'b0;

  localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd256;
  localparam logic [SHADE_W-1:0] SHADE_LAST   = SHADE_W'(PALETTE_LEN - 1);

  // Palette shades
  localparam logic [SHADE_W-1:0] SHADE_PURPLE    = 3'd0;
  localparam logic [SHADE_W-1:0] SHADE_BLUE      = 3'd1;
  localparam logic [SHADE_W-1:0] SHADE_TURQUOISE = 3'd2;
  localparam logic [SHADE_W-1:0] SHADE_YELLOW    = 3'd3;
  localparam logic [SHADE_W-1:0] SHADE_WHITE     = 3'd4;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [ITER_W-1:0]   iterations;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } result_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic              start;
    logic              raw;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] res;
  } mul_rsp_t;

  function automatic rgb_t palette_rgb(input logic [SHADE_W-1:0] shade);
    rgb_t c;
    case (shade)
      SHADE_PURPLE:    c = '{red: 8'd160, green: 8'd32,  blue: 8'd240};
      SHADE_BLUE:      c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      SHADE_TURQUOISE: c = '{red: 8'd64,  green: 8'd224, blue: 8'd208};
      SHADE_YELLOW:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
      SHADE_WHITE:     c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      default:         c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/mandelbrot_escape_time_pixel.sv =====
// Escape-time pixel evaluator: sequencer, configuration register and result output.
//
// One pixel is taken when start is high and busy is low; busy then stays high until the
// pixel is finished, and the result appears on result_o for exactly one cycle with done_o
// high (the receiver cannot stall it). All multiplications go through one shared
// multiplier that forms P partial products of 32x32 bits, P = 1 for FRACTION_BITS up to 31
// and 4 above. Mapping the pixel to the plane costs two products; each iteration costs a
// check state plus three products (re*re, im*im, re*im). A pixel stops at the check
// (limit reached or a coordinate at 2.0 or beyond) or when the |z|^2 test lets it escape,
// and the next pixel may be started in the cycle its result is shown. max_iterations is
// written over the APB port at byte address 0 and must only be changed while busy is low.
module mandelbrot_escape_time_pixel import mbet_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 1920,
  parameter int unsigned SCREEN_HEIGHT = 1080,
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pixel_t                pixel_i,
  output logic                  done_o,
  output result_t               result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [WORD_W-1:0] ONE     = WORD_W'(1) << FRACTION_BITS;
  localparam logic [WORD_W-1:0] TWO     = ONE << 1;
  localparam logic [WORD_W-1:0] FOUR    = ONE << 2;
  localparam logic [WORD_W-1:0] NEG_TWO = ~TWO + WORD_W'(1);
  localparam logic [WORD_W-1:0] STEP_X  =
    (FOUR + WORD_W'(SCREEN_WIDTH / 2)) / WORD_W'(SCREEN_WIDTH);
  localparam logic [WORD_W-1:0] STEP_Y  =
    (FOUR + WORD_W'(SCREEN_HEIGHT / 2)) / WORD_W'(SCREEN_HEIGHT);

  typedef enum logic [2:0] {S_IDLE, S_CRE, S_CIM, S_CHECK, S_RR, S_II, S_RI} state_e;

  state_e             state_q, state_d;
  logic [COORD_W-1:0] py_q, py_d;
  logic [ITER_W-1:0]  max_run_q, max_run_d;
  logic [WORD_W-1:0]  cre_q, cre_d, cim_q, cim_d;
  logic [WORD_W-1:0]  re_q, re_d, im_q, im_d;
  logic [WORD_W-1:0]  rr_q, rr_d, ii_q, ii_d;
  logic [ITER_W-1:0]  count_q, count_d;
  logic [SHADE_W-1:0] shade_q, shade_d;
  mul_req_t           mreq_q, mreq_d;
  logic               done_q, done_d;
  result_t            result_q, result_d;
  logic [ITER_W-1:0]  max_iter_q;

  mul_rsp_t           mrsp;
  logic               cfg_wr;
  logic [0:0]         reg_idx;
  logic               accept;
  logic               limit_hit;
  logic               out_of_range;
  logic [WORD_W-1:0]  mag_sum;
  rgb_t               shade_rgb;

  mbet_mul #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mreq_q),
    .rsp_o (mrsp)
  );

  // Configuration register
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_MAX_ITER) ? {(APB_DATA_W-ITER_W)'(0), max_iter_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
    end else if (cfg_wr && reg_idx == REG_MAX_ITER) begin
      max_iter_q <= pwdata[ITER_W-1:0];
    end
  end

  // Loop conditions
  assign accept       = start && !busy;
  assign limit_hit    = (count_q >= max_run_q);
  assign out_of_range = ($signed(re_q) >= $signed(TWO)) || ($signed(re_q) <= $signed(NEG_TWO))
                     || ($signed(im_q) >= $signed(TWO)) || ($signed(im_q) <= $signed(NEG_TWO));
  assign mag_sum      = rr_q + mrsp.res;
  assign shade_rgb    = palette_rgb(shade_q);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    py_d      = py_q;
    max_run_d = max_run_q;
    cre_d     = cre_q;
    cim_d     = cim_q;
    re_d      = re_q;
    im_d      = im_q;
    rr_d      = rr_q;
    ii_d      = ii_q;
    count_d   = count_q;
    shade_d   = shade_q;
    mreq_d    = mreq_q;
    mreq_d.start = 1'b0;
    done_d    = 1'b0;
    result_d  = result_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          py_d      = pixel_i.pixel_y;
          max_run_d = max_iter_q;
          count_d   = '0;
          shade_d   = SHADE_PURPLE;
          mreq_d    = '{start: 1'b1, raw: 1'b1,
                        a: WORD_W'(pixel_i.pixel_x), b: STEP_X};
          state_d   = S_CRE;
        end
      end
      S_CRE: begin
        if (mrsp.done) begin
          cre_d   = mrsp.res - TWO;
          mreq_d  = '{start: 1'b1, raw: 1'b1, a: WORD_W'(py_q), b: STEP_Y};
          state_d = S_CIM;
        end
      end
      S_CIM: begin
        if (mrsp.done) begin
          cim_d   = TWO - mrsp.res;
          re_d    = '0;
          im_d    = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // Stop at the limit (black) or on an obvious escape; else square re
        if (limit_hit || out_of_range) begin
          result_d.iterations = count_q;
          {result_d.red, result_d.green, result_d.blue} = limit_hit ? '0 : shade_rgb;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mreq_d  = '{start: 1'b1, raw: 1'b0, a: re_q, b: re_q};
          state_d = S_RR;
        end
      end
      S_RR: begin
        if (mrsp.done) begin
          rr_d    = mrsp.res;
          mreq_d  = '{start: 1'b1, raw: 1'b0, a: im_q, b: im_q};
          state_d = S_II;
        end
      end
      S_II: begin
        // Escape test on |z|^2, else form the cross term
        if (mrsp.done) begin
          ii_d = mrsp.res;
          if ($signed(mag_sum) >= $signed(FOUR)) begin
            result_d.iterations = count_q;
            {result_d.red, result_d.green, result_d.blue} = shade_rgb;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            mreq_d  = '{start: 1'b1, raw: 1'b0, a: re_q, b: im_q};
            state_d = S_RI;
          end
        end
      end
      S_RI: begin
        // Advance z and the count
        if (mrsp.done) begin
          re_d    = rr_q - ii_q + cre_q;
          im_d    = {mrsp.res[WORD_W-2:0], 1'b0} + cim_q;
          count_d = count_q + ITER_W'(1);
          shade_d = (shade_q == SHADE_LAST) ? SHADE_PURPLE : shade_q + SHADE_W'(1);
          state_d = S_CHECK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      py_q      <= '0;
      max_run_q <= MAX_ITER_RST;
      cre_q     <= '0;
      cim_q     <= '0;
      re_q      <= '0;
      im_q      <= '0;
      rr_q      <= '0;
      ii_q      <= '0;
      count_q   <= '0;
      shade_q   <= SHADE_PURPLE;
      mreq_q    <= '0;
      done_q    <= 1'b0;
      result_q  <= '0;
    end else begin
      state_q   <= state_d;
      py_q      <= py_d;
      max_run_q <= max_run_d;
      cre_q     <= cre_d;
      cim_q     <= cim_d;
      re_q      <= re_d;
      im_q      <= im_d;
      rr_q      <= rr_d;
      ii_q      <= ii_d;
      count_q   <= count_d;
      shade_q   <= shade_d;
      mreq_q    <= mreq_d;
      done_q    <= done_d;
      result_q  <= result_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  // An accepted pixel keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("pixel accepted but block not busy");

  // A result beat is shown only once the block is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  // The count never passes the limit latched for this pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (count_q <= max_run_q))
    else $error("iteration count beyond limit");

  // Black exactly when the limit was reached
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.iterations == max_run_q) ==
                (result_o.red == '0 && result_o.green == '0 && result_o.blue == '0)))
    else $error("colour does not match limit outcome");

endmodule

// ===== hw/rtl/mbet_mul.sv =====
// Multi-cycle signed multiplier built from 32x32 partial products, fixed-point or raw.
module mbet_mul import mbet_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  // Operands never exceed 2.0 in magnitude, so FRACTION_BITS+1 magnitude bits
  localparam int unsigned MAG_W   = FRACTION_BITS + 1;
  localparam int unsigned N_CHUNK = (MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned OPD_W   = N_CHUNK * CHUNK_W;
  localparam int unsigned ACC_W   = 2 * OPD_W;
  localparam int unsigned PROD_W  = 2 * MAG_W;
  localparam int unsigned IDX_W   = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;
  localparam int unsigned WGT_W   = $clog2(2 * N_CHUNK);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_CHUNK - 1);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_e;

  mstate_e              state_q, state_d;
  logic [OPD_W-1:0]     ma_q, ma_d, mb_q, mb_d;
  logic                 neg_q, neg_d, raw_q, raw_d;
  logic [IDX_W-1:0]     i_q, i_d, j_q, j_d;
  logic                 issue_q, issue_d;
  logic [2*CHUNK_W-1:0] pp_q, pp_d;
  logic                 ppv_q, ppv_d;
  logic [WGT_W-1:0]     ppw_q, ppw_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [WORD_W-1:0]    res_q, res_d;
  logic                 done_q, done_d;

  logic [WORD_W-1:0]    abs_a, abs_b;
  logic [CHUNK_W-1:0]   chunk_a, chunk_b;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    quot;
  logic                 rem_nz;
  logic [WORD_W-1:0]    quot_w;

  // Operand magnitudes and the current pair of digits
  assign abs_a   = req_i.a[WORD_W-1] ? (~req_i.a + WORD_W'(1)) : req_i.a;
  assign abs_b   = req_i.b[WORD_W-1] ? (~req_i.b + WORD_W'(1)) : req_i.b;
  assign chunk_a = ma_q[CHUNK_W*i_q +: CHUNK_W];
  assign chunk_b = mb_q[CHUNK_W*j_q +: CHUNK_W];

  // Floor shift of the signed product: negate magnitude, round toward minus infinity
  assign prod   = acc_q[PROD_W-1:0];
  assign quot   = raw_q ? prod : (prod >> FRACTION_BITS);
  assign rem_nz = !raw_q && (|prod[FRACTION_BITS-1:0]);
  assign quot_w = WORD_W'(quot);

  always_comb begin
    state_d = state_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    neg_d   = neg_q;
    raw_d   = raw_q;
    i_d     = i_q;
    j_d     = j_q;
    issue_d = issue_q;
    pp_d    = pp_q;
    ppv_d   = 1'b0;
    ppw_d   = ppw_q;
    acc_d   = acc_q;
    res_d   = res_q;
    done_d  = 1'b0;
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          ma_d    = OPD_W'(abs_a[MAG_W-1:0]);
          mb_d    = OPD_W'(abs_b[MAG_W-1:0]);
          neg_d   = req_i.a[WORD_W-1] ^ req_i.b[WORD_W-1];
          raw_d   = req_i.raw;
          i_d     = '0;
          j_d     = '0;
          issue_d = 1'b1;
          acc_d   = '0;
          state_d = M_RUN;
        end
      end
      M_RUN: begin
        // Issue one partial product per cycle
        if (issue_q) begin
          pp_d  = (2*CHUNK_W)'(chunk_a) * (2*CHUNK_W)'(chunk_b);
          ppv_d = 1'b1;
          ppw_d = WGT_W'(i_q) + WGT_W'(j_q);
          if (j_q == LAST_IDX) begin
            j_d = '0;
            if (i_q == LAST_IDX) begin
              i_d     = '0;
              issue_d = 1'b0;
            end else begin
              i_d = i_q + IDX_W'(1);
            end
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
        // Accumulate the product registered last cycle
        if (ppv_q) begin
          acc_d = acc_q + (ACC_W'(pp_q) << (CHUNK_W * ppw_q));
        end
        if (!issue_q && ppv_q) begin
          state_d = M_FIN;
        end
      end
      M_FIN: begin
        res_d   = neg_q ? (~quot_w + WORD_W'(!rem_nz)) : quot_w;
        done_d  = 1'b1;
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      ma_q    <= '0;
      mb_q    <= '0;
      neg_q   <= 1'b0;
      raw_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      issue_q <= 1'b0;
      pp_q    <= '0;
      ppv_q   <= 1'b0;
      ppw_q   <= '0;
      acc_q   <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ma_q    <= ma_d;
      mb_q    <= mb_d;
      neg_q   <= neg_d;
      raw_q   <= raw_d;
      i_q     <= i_d;
      j_q     <= j_d;
      issue_q <= issue_d;
      pp_q    <= pp_d;
      ppv_q   <= ppv_d;
      ppw_q   <= ppw_d;
      acc_q   <= acc_d;
      res_q   <= res_d;
      done_q  <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  // A new operation arrives only while the unit is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == M_IDLE))
    else $error("multiplier started while busy");

  // The run phase ends only once its last partial product has been accumulated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == M_RUN && !issue_q) |-> ppv_q)
    else $error("multiplier run phase without pending partial product");

  // Completion is a single-cycle pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done)
    else $error("multiplier done held for more than one cycle");

endmodule

// ===== bench/mandelbrot_escape_time_pixel_tb.sv =====
// Self-checking bench for the escape-time pixel evaluator: predicted counts and colours.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_tb;
  import mbet_pkg::*;

  localparam int unsigned     SCR_W        = 1920;
  localparam int unsigned     SCR_H        = 1080;
  localparam int unsigned     FRAC         = 28;
  localparam longint unsigned ONE_FX       = 64'd1 << FRAC;
  localparam longint unsigned STEP_X       = ((ONE_FX << 2) + SCR_W / 2) / SCR_W;
  localparam longint unsigned STEP_Y       = ((ONE_FX << 2) + SCR_H / 2) / SCR_H;
  localparam longint          TWO_FX       = 64'sd1 <<< (FRAC + 1);
  localparam int unsigned     REG_UNMAPPED = 1;
  localparam int unsigned     STALL_LIMIT  = 100000;
  localparam int unsigned     DEEP_CAP     = 1500;
  localparam int unsigned     PHASES       = 12;
  localparam int unsigned     PHASE_BEATS  = 140;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  pixel_t                pixel_i = '0;
  logic                  done_o;
  result_t               result_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  result_t     pending_shades[$];
  result_t     head_shade;
  int unsigned iter_limit = MAX_ITER_RST;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;

  mandelbrot_escape_time_pixel #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H),
    .FRACTION_BITS(FRAC)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pixel_i (pixel_i),
    .done_o  (done_o),
    .result_o(result_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Fixed-point product: exact 128-bit product, floor shift, low word kept
  function automatic logic [63:0] fx_product(input logic [63:0] a, input logic [63:0] b);
    logic signed [127:0] wide;
    wide = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    return wide[FRAC +: 64];
  endfunction

  function automatic bit inside_radius(input logic [63:0] re, input logic [63:0] im);
    longint sr;
    longint si;
    longint mag;
    sr = re;
    si = im;
    if (sr >= TWO_FX || sr <= -TWO_FX || si >= TWO_FX || si <= -TWO_FX) return 1'b0;
    mag = fx_product(re, re) + fx_product(im, im);
    return mag < 2 * TWO_FX;
  endfunction

  // Iterate z = z*z + c from the origin until escape or the limit
  function automatic int unsigned escape_count(input pixel_t p, input int unsigned limit);
    logic [63:0] c_re;
    logic [63:0] c_im;
    logic [63:0] re;
    logic [63:0] im;
    logic [63:0] rr;
    logic [63:0] ii;
    logic [63:0] ri;
    int unsigned n;
    c_re = 64'(p.pixel_x) * STEP_X - 2 * ONE_FX;
    c_im = 2 * ONE_FX - 64'(p.pixel_y) * STEP_Y;
    re = '0;
    im = '0;
    n  = 0;
    while (n < limit && inside_radius(re, im)) begin
      rr = fx_product(re, re);
      ii = fx_product(im, im);
      ri = fx_product(re, im);
      re = rr - ii + c_re;
      im = (ri << 1) + c_im;
      n++;
    end
    return n;
  endfunction

  function automatic logic [23:0] shade_colour(input int unsigned n);
    logic [23:0] rgb;
    case (SHADE_W'(n % PALETTE_LEN))
      SHADE_PURPLE:    rgb = {8'd160, 8'd32,  8'd240};
      SHADE_BLUE:      rgb = {8'd0,   8'd0,   8'd255};
      SHADE_TURQUOISE: rgb = {8'd64,  8'd224, 8'd208};
      SHADE_YELLOW:    rgb = {8'd255, 8'd255, 8'd0};
      default:         rgb = {8'd255, 8'd255, 8'd255};
    endcase
    return rgb;
  endfunction

  function automatic result_t predict_pixel(input pixel_t p, input int unsigned limit);
    result_t     r;
    int unsigned n;
    n = escape_count(p, limit);
    r.iterations = n[ITER_W-1:0];
    {r.red, r.green, r.blue} = (n == limit) ? 24'h0 : shade_colour(n);
    return r;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    if ($urandom_range(0, 99) < 85) begin
      p.pixel_x = COORD_W'($urandom_range(0, SCR_W - 1));
      p.pixel_y = COORD_W'($urandom_range(0, SCR_H - 1));
    end else begin
      p.pixel_x = COORD_W'($urandom);
      p.pixel_y = COORD_W'($urandom);
    end
    return p;
  endfunction

  // Mostly back-to-back, now and then a short or a long pause
  function automatic int unsigned sender_gap(input bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 300);
  endfunction

  function automatic pixel_t at(input int unsigned x, input int unsigned y);
    pixel_t p;
    p.pixel_x = COORD_W'(x);
    p.pixel_y = COORD_W'(y);
    return p;
  endfunction

  task automatic report_result(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: expected it=%0d rgb=%0d/%0d/%0d, got it=%0d rgb=%0d/%0d/%0d", what,
               want.iterations, want.red, want.green, want.blue,
               got.iterations, got.red, got.green, got.blue);
  endtask

  // Hold start until the block takes the beat, then log its prediction
  task automatic send_pixel(input pixel_t p, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    pixel_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_shades.push_back(predict_pixel(p, iter_limit));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_shades.size() != 0 || busy) @(posedge clk_i);
  endtask

  // APB write: setup then access, only once the block has gone idle
  task automatic write_register(input int unsigned index, input logic [APB_DATA_W-1:0] value);
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(index * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == REG_MAX_ITER) iter_limit = value[ITER_W-1:0];
    // Leave the bus idle so the next transfer starts on a later edge
    @(posedge clk_i);
  endtask

  // Corners, centre, points inside the set and coordinates off the screen
  task automatic test_directed_points();
    send_pixel(at(0, 0), 0);
    send_pixel(at(SCR_W - 1, 0), 0);
    send_pixel(at(0, SCR_H - 1), 1);
    send_pixel(at(SCR_W - 1, SCR_H - 1), 0);
    send_pixel(at(960, 540), 0);
    send_pixel(at(480, 540), 2);
    send_pixel(at(960, 270), 0);
    send_pixel(at(1080, 540), 0);
    send_pixel(at(600, 513), 0);
    send_pixel(at(0, 540), 0);
    send_pixel(at(2047, 2047), 0);
    send_pixel(at(2047, 0), 0);
    send_pixel(at(0, 2047), 0);
    send_pixel(at(SCR_W, SCR_H), 0);
    send_pixel(at(11'h555, 11'h2AA), 0);
  endtask

  // A zero limit gives no iterations and black; a limit of one follows
  task automatic test_zero_limit();
    write_register(REG_MAX_ITER, 32'd0);
    send_pixel(at(960, 540), 0);
    send_pixel(at(0, 0), 0);
    send_pixel(at(2047, 2047), 3);
    write_register(REG_MAX_ITER, 32'd1);
    send_pixel(at(960, 540), 0);
    send_pixel(at(0, 0), 0);
  endtask

  // Writes to an unmapped index are dropped; upper data bits are ignored
  task automatic test_register_decode();
    write_register(REG_MAX_ITER, 32'd300);
    write_register(REG_UNMAPPED, 32'd2);
    send_pixel(at(960, 540), 0);
    write_register(REG_MAX_ITER, 32'hFFFF_0003);
    send_pixel(at(960, 540), 0);
    send_pixel(at(1200, 400), 0);
  endtask

  task automatic test_random_sweep();
    int unsigned limit;
    int unsigned drain_at;
    bit          burst;
    for (int unsigned k = 0; k < PHASES; k++) begin
      if (k == 0) limit = 1;
      else if (k == 3 || k == 7) limit = MAX_ITER_RST;
      else limit = $urandom_range(2, 120);
      write_register(REG_MAX_ITER, APB_DATA_W'(limit));
      burst    = ($urandom_range(0, 3) == 0);
      drain_at = $urandom_range(10, PHASE_BEATS - 10);
      for (int unsigned i = 0; i < PHASE_BEATS; i++) begin
        if (i == drain_at) wait_for_results();
        send_pixel(random_pixel(), sender_gap(burst));
      end
    end
  endtask

  // Widest limit, with pixels that escape within a bounded count
  task automatic test_deep_limit();
    pixel_t p;
    write_register(REG_MAX_ITER, 32'h0000_FFFF);
    for (int unsigned i = 0; i < 120; i++) begin
      do p = random_pixel(); while (escape_count(p, DEEP_CAP) >= DEEP_CAP);
      send_pixel(p, sender_gap(1'b0));
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_shades.size() == 0) begin
        report_result("unexpected result", '0, result_o);
      end else begin
        head_shade = pending_shades.pop_front();
        if (result_o.iterations !== head_shade.iterations ||
            result_o.red !== head_shade.red || result_o.green !== head_shade.green ||
            result_o.blue !== head_shade.blue)
          report_result("mismatch", head_shade, result_o);
      end
    end
  end

  // Drop the run if no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_points();
    test_zero_limit();
    test_register_decode();
    test_random_sweep();
    test_deep_limit();
    wait_for_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_shades.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
